[sv/bfe_pkg.sv]
// bfe_pkg: shared constants, codes and types of the bitmap fragment expander
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bfe_pkg;

	// default geometry
	localparam int DEF_SUBPIXEL_BITS = 4;
	localparam int DEF_COORD_BITS    = 12;
	localparam int DEF_FIFO_DEPTH    = 4;

	// widest coordinate the job queue carries (top of the coordinate range)
	localparam int COORD_MAX_W = 15;
	localparam int FRAG_W      = 12;

	// configuration port
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPAN_W   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPAN_H   = 3'd4;

	localparam logic [1:0]  RST_ALIGN = 2'd2;
	localparam logic [12:0] RST_SPAN  = 13'd4096;

	// item kinds
	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;

	typedef struct packed {
		logic [1:0]  align_code;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [12:0] span_w;
		logic [12:0] span_h;
	} cfg_t;

	// one classified data byte: base pixel, row and the pixels to draw
	typedef struct packed {
		logic [COORD_MAX_W-1:0] x;
		logic [COORD_MAX_W-1:0] y;
		logic [7:0]             mask;
	} job_t;

endpackage

`default_nettype wire

[sv/bfe_fifo.sv]
// bfe_fifo: short job queue between the classifying front and the emitting back
// depends on bfe_pkg (job_t)
`timescale 1ns / 1ps
`default_nettype none

module bfe_fifo import bfe_pkg::*; #(
	parameter int DEPTH = DEF_FIFO_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire job_t             push_job,
	input  wire logic             pop,
	output job_t                  pop_job,
	output logic [CNT_W-1:0]      count,
	output logic                  empty
);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_job = slot_q[rd_ptr_q];
	assign count   = count_q;
	assign empty   = (count_q == '0);

endmodule

`default_nettype wire

[sv/bfe_front.sv]
// bfe_front: accepts items, keeps raster and bitmap state, classifies data bytes
// depends on bfe_pkg (codes, cfg_t, job_t); feeds bfe_fifo
`timescale 1ns / 1ps
`default_nettype none

module bfe_front import bfe_pkg::*; #(
	parameter int SUBPIXEL_BITS = DEF_SUBPIXEL_BITS,
	parameter int COORD_BITS    = DEF_COORD_BITS,
	parameter int FIFO_DEPTH    = DEF_FIFO_DEPTH,
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic signed [19:0] value_x,
	input  wire logic signed [19:0] value_y,
	input  wire logic signed [19:0] step_x,
	input  wire logic signed [19:0] step_y,
	input  wire logic [11:0]        size_w,
	input  wire logic [11:0]        size_h,
	input  wire logic               raster_ok,
	input  wire logic [7:0]         data_byte,
	input  wire cfg_t               cfg,
	input  wire logic [CNT_W-1:0]   q_count,
	output logic                    q_push,
	output job_t                    q_job
);

	localparam int XW = 24 - SUBPIXEL_BITS;
	localparam int PW = XW + 2;
	localparam logic signed [21:0]   HALF      = 22'(1 << (SUBPIXEL_BITS - 1));
	localparam logic signed [PW-1:0] COORD_LIM = PW'(1 << COORD_BITS);

	logic [19:0]          pos_x_q, pos_y_q;
	logic                 raster_valid_q;
	logic [19:0]          move_x_q, move_y_q;
	logic signed [XW-1:0] start_x_q, row_y_q;
	logic [11:0]          width_q, rows_q;
	logic [9:0]           byte_q;
	logic                 active_q, drawn_q;

	logic                 s1_valid_q;
	logic signed [XW:0]   s1_x_q;
	logic signed [XW-1:0] s1_y_q;
	logic [7:0]           s1_cand_q;

	logic                 accept;
	logic signed [21:0]   sum_x, sum_y;
	logic signed [XW-1:0] anchor_x, anchor_y;
	logic [9:0]           nbytes, align_m1;
	logic [10:0]          row_bytes, byte_next;
	logic                 row_end;
	logic [12:0]          first_px;
	logic [7:0]           cand;
	logic signed [XW:0]   x0;
	logic                 no_area;

	assign accept   = in_valid && !in_stall;
	assign in_stall = ({1'b0, q_count} + (CNT_W + 1)'(s1_valid_q)) >= (CNT_W + 1)'(FIFO_DEPTH);

	// pixel anchor: floor((raster + offset + half) / 2^subpixel)
	assign sum_x    = $signed({{2{pos_x_q[19]}}, pos_x_q}) + $signed({{2{value_x[19]}}, value_x})
		+ HALF;
	assign sum_y    = $signed({{2{pos_y_q[19]}}, pos_y_q}) + $signed({{2{value_y[19]}}, value_y})
		+ HALF;
	assign anchor_x = XW'(sum_x >>> SUBPIXEL_BITS);
	assign anchor_y = XW'(sum_y >>> SUBPIXEL_BITS);
	assign no_area  = (size_w == '0) || (size_h == '0);

	// row length in bytes, rounded up to the unpack alignment
	assign nbytes    = 10'((13'(width_q) + 13'd7) >> 3);
	assign align_m1  = 10'((11'd1 << cfg.align_code) - 11'd1);
	assign row_bytes = (11'(nbytes) + 11'(align_m1)) & ~11'(align_m1);
	assign byte_next = 11'(byte_q) + 11'd1;
	assign row_end   = byte_next >= row_bytes;

	assign first_px = {byte_q, 3'b000};
	assign x0       = (XW + 1)'(start_x_q) + (XW + 1)'($signed({1'b0, first_px}));

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			cand[i] = data_byte[7-i] && ((14'(first_px) + 14'(i)) < 14'(width_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			raster_valid_q <= 1'b1;
			move_x_q       <= '0;
			move_y_q       <= '0;
			start_x_q      <= '0;
			row_y_q        <= '0;
			width_q        <= '0;
			rows_q         <= '0;
			byte_q         <= '0;
			active_q       <= 1'b0;
			drawn_q        <= 1'b0;
			s1_valid_q     <= 1'b0;
		end else begin
			s1_valid_q <= 1'b0;
			if (accept) begin
				case (command)
					CMD_SET: begin
						active_q       <= 1'b0;
						pos_x_q        <= value_x;
						pos_y_q        <= value_y;
						raster_valid_q <= raster_ok;
					end
					CMD_BEGIN: begin
						active_q <= 1'b0;
						move_x_q <= step_x;
						move_y_q <= step_y;
						if (no_area) begin
							if (raster_valid_q) begin
								pos_x_q <= pos_x_q + step_x;
								pos_y_q <= pos_y_q + step_y;
							end
						end else begin
							drawn_q <= raster_valid_q;
							if (raster_valid_q) begin
								start_x_q <= anchor_x;
								row_y_q   <= anchor_y;
							end
							width_q  <= size_w;
							rows_q   <= size_h;
							byte_q   <= '0;
							active_q <= 1'b1;
						end
					end
					CMD_DATA: begin
						if (active_q) begin
							s1_valid_q <= drawn_q && (cand != '0);
							if (row_end) begin
								byte_q  <= '0;
								row_y_q <= row_y_q + 1'b1;
								rows_q  <= rows_q - 1'b1;
								if (rows_q == 12'd1) begin
									active_q <= 1'b0;
									if (drawn_q) begin
										pos_x_q <= pos_x_q + move_x_q;
										pos_y_q <= pos_y_q + move_y_q;
									end
								end
							end else begin
								byte_q <= 10'(byte_next);
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// byte stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_x_q    <= x0;
			s1_y_q    <= row_y_q;
			s1_cand_q <= cand;
		end
	end

	// scissor and surface test of the eight pixels and of the row
	logic signed [PW-1:0] px [8];
	logic signed [PW-1:0] dx [8];
	logic signed [PW-1:0] py, dy;
	logic [7:0]           x_ok;
	logic                 row_ok;
	logic [7:0]           mask;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			px[i]   = PW'(s1_x_q) + PW'(i);
			dx[i]   = px[i] - $signed(PW'(cfg.origin_x));
			x_ok[i] = (px[i] < COORD_LIM) && (dx[i] >= 0) && (dx[i] < $signed(PW'(cfg.span_w)));
		end
		py     = PW'(s1_y_q);
		dy     = py - $signed(PW'(cfg.origin_y));
		row_ok = (py >= 0) && (py < COORD_LIM) && (dy >= 0) && (dy < $signed(PW'(cfg.span_h)));
		mask   = s1_cand_q & x_ok & {8{row_ok}};
	end

	assign q_push     = s1_valid_q && (mask != '0);
	assign q_job.x    = COORD_MAX_W'(s1_x_q[COORD_BITS-1:0]);
	assign q_job.y    = COORD_MAX_W'(s1_y_q[COORD_BITS-1:0]);
	assign q_job.mask = mask;

endmodule

`default_nettype wire

[sv/bfe_back.sv]
// bfe_back: drains queued jobs into the output register, one fragment per cycle
// unless the output stalls; depends on bfe_pkg (job_t, widths); fed by bfe_fifo
`timescale 1ns / 1ps
`default_nettype none

module bfe_back import bfe_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire job_t          q_job,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [FRAG_W-1:0]  frag_x,
	output logic [FRAG_W-1:0]  frag_y,
	output logic               last_of_run
);

	localparam logic [COORD_MAX_W-1:0] CMASK = COORD_MAX_W'((1 << COORD_BITS) - 1);

	logic [7:0]             cur_mask_q;
	logic [COORD_MAX_W-1:0] cur_x_q, cur_y_q;
	logic                   out_valid_q;
	logic [FRAG_W-1:0]      out_x_q, out_y_q;
	logic                   out_last_q;

	logic                   adv, have, emit, load;
	logic [2:0]             idx;
	logic [7:0]             rest;
	logic [COORD_MAX_W-1:0] x_sum;

	always_comb begin
		idx = '0;
		for (int i = 7; i >= 0; i--) begin
			if (cur_mask_q[i]) begin
				idx = 3'(i);
			end
		end
	end

	assign rest  = cur_mask_q & ~(8'd1 << idx);
	assign adv   = !out_valid_q || !out_stall;
	assign have  = (cur_mask_q != '0);
	assign emit  = adv && have;
	assign load  = !have || (emit && (rest == '0));
	assign q_pop = load && !q_empty;
	assign x_sum = (cur_x_q + COORD_MAX_W'(idx)) & CMASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_mask_q <= q_job.mask;
			end else if (emit) begin
				cur_mask_q <= rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_x_q <= q_job.x;
			cur_y_q <= q_job.y;
		end
		if (emit) begin
			out_x_q    <= FRAG_W'(x_sum);
			out_y_q    <= FRAG_W'(cur_y_q);
			out_last_q <= (rest == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign frag_x      = out_x_q;
	assign frag_y      = out_y_q;
	assign last_of_run = out_last_q;

endmodule

`default_nettype wire

[sv/bitmap_fragment_expander.sv]
// bitmap_fragment_expander: top level, configuration registers, front, job queue, back
// depends on bfe_pkg, bfe_front, bfe_fifo, bfe_back
// path: a data byte passes the byte stage register, the job queue, the current job register and the output register
// throughput: one item per cycle while bytes draw at most one fragment and the output is not
//   stalled; a byte that draws several fragments, up to 8 per byte, holds the fragment output until all have left
// reset: arst_n clears raster, bitmap and queue state and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module bitmap_fragment_expander import bfe_pkg::*; #(
	parameter int SUBPIXEL_BITS = DEF_SUBPIXEL_BITS,
	parameter int COORD_BITS    = DEF_COORD_BITS,
	parameter int FIFO_DEPTH    = DEF_FIFO_DEPTH,
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration writes
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             command,
	input  wire logic signed [19:0]     value_x,
	input  wire logic signed [19:0]     value_y,
	input  wire logic signed [19:0]     step_x,
	input  wire logic signed [19:0]     step_y,
	input  wire logic [11:0]            size_w,
	input  wire logic [11:0]            size_h,
	input  wire logic                   raster_ok,
	input  wire logic [7:0]             data_byte,
	// fragments
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [FRAG_W-1:0]           frag_x,
	output logic [FRAG_W-1:0]           frag_y,
	output logic                        last_of_run
);

	// configuration registers; the user must write them only while the block is idle (the block
	// itself does not enforce this), so the front reads them directly
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.align_code <= RST_ALIGN;
			cfg_q.origin_x   <= '0;
			cfg_q.origin_y   <= '0;
			cfg_q.span_w     <= RST_SPAN;
			cfg_q.span_h     <= RST_SPAN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALIGN:    cfg_q.align_code <= cfg_data[1:0];
				CFG_ORIGIN_X: cfg_q.origin_x   <= cfg_data[11:0];
				CFG_ORIGIN_Y: cfg_q.origin_y   <= cfg_data[11:0];
				CFG_SPAN_W:   cfg_q.span_w     <= cfg_data;
				CFG_SPAN_H:   cfg_q.span_h     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front to queue
	logic             q_push;
	job_t             q_push_job;
	logic [CNT_W-1:0] q_count;
	// queue to back
	logic             q_pop;
	job_t             q_pop_job;
	logic             q_empty;

	// front: item transfer, raster/bitmap state, byte classification with the
	// width, row and scissor tests; pushes only bytes that draw something
	bfe_front #(
		.SUBPIXEL_BITS (SUBPIXEL_BITS),
		.COORD_BITS    (COORD_BITS),
		.FIFO_DEPTH    (FIFO_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.value_x   (value_x),
		.value_y   (value_y),
		.step_x    (step_x),
		.step_y    (step_y),
		.size_w    (size_w),
		.size_h    (size_h),
		.raster_ok (raster_ok),
		.data_byte (data_byte),
		.cfg       (cfg_q),
		.q_count   (q_count),
		.q_push    (q_push),
		.q_job     (q_push_job)
	);

	// short queue decouples classification from fragment emission
	bfe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.pop      (q_pop),
		.pop_job  (q_pop_job),
		.count    (q_count),
		.empty    (q_empty)
	);

	// back: walks the pixel mask of each job, one fragment transfer per cycle while the output is not stalled
	bfe_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (q_pop_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frag_x      (frag_x),
		.frag_y      (frag_y),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

[sv/bfe_checker.sv]
// bfe_checker: port-level assertions on the fragment output, bound to the top level
// depends on bfe_pkg (FRAG_W); binds to bitmap_fragment_expander
`timescale 1ns / 1ps
`default_nettype none

module bfe_checker import bfe_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [FRAG_W-1:0] frag_x,
	input wire logic [FRAG_W-1:0] frag_y,
	input wire logic              last_of_run
);

	logic              xfer;
	logic [2:0]        run_cnt_q;
	logic [FRAG_W-1:0] prev_x_q, prev_y_q;

	assign xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (xfer) begin
			run_cnt_q <= last_of_run ? '0 : run_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			prev_x_q <= frag_x;
			prev_y_q <= frag_y;
		end
	end

	// no fragment offered in the cycle after a reset edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("fragment valid during reset");

	// a stalled fragment stays offered and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(frag_x) && $stable(frag_y)
			&& $stable(last_of_run)))
		else $error("stalled fragment changed");

	// one byte never yields more than eight fragments
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && run_cnt_q == 3'd7) |-> last_of_run)
		else $error("run longer than eight fragments");

	// fragments of one byte share the row and none repeats the pixel of the one before it
	a_run_row: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && run_cnt_q != 3'd0) |-> (frag_y == prev_y_q && frag_x != prev_x_q))
		else $error("run left its row or repeated a pixel");

endmodule

bind bitmap_fragment_expander bfe_checker u_bfe_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking bench for bitmap_fragment_expander
// predicts the fragments of every input transfer and checks them in order at the fragment port
// depends on bfe_pkg and bitmap_fragment_expander
`timescale 1ns / 1ps

module testbench;
	import bfe_pkg::*;

	// command code the block must ignore
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SUBPIX        = DEF_SUBPIXEL_BITS;
	localparam int SURFACE       = 1 << DEF_COORD_BITS;
	// quiet cycles after the last fragment: data latency plus the job queue draining
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int CYCLE_LIMIT   = 300000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [19:0] vx;
		logic [19:0] vy;
		logic [19:0] sx;
		logic [19:0] sy;
		logic [11:0] w;
		logic [11:0] h;
		logic        ok;
		logic [7:0]  data;
	} bitmap_item_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic        last;
	} frag_t;

	typedef enum {STALL_NONE, STALL_COIN, STALL_BEAT, STALL_HEAVY} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	bitmap_item_t drv_item = '0;
	wire in_stall, out_valid, last_of_run;
	wire [FRAG_W-1:0] frag_x, frag_y;

	// items waiting for the driver, fragments waiting for the port
	bitmap_item_t bitmap_items[$];
	frag_t pending_frags[$];

	// model copy of the registers
	int cfg_align = RST_ALIGN;
	int cfg_org_x = 0;
	int cfg_org_y = 0;
	int cfg_span_w = RST_SPAN;
	int cfg_span_h = RST_SPAN;

	// model copy of the raster and bitmap state
	logic [19:0] pos_x = '0;
	logic [19:0] pos_y = '0;
	logic        pos_ok = 1'b1;
	logic [19:0] move_x = '0;
	logic [19:0] move_y = '0;
	int          row_x0 = 0;
	int          row_y = 0;
	int          bm_width = 0;
	int          rows_left = 0;
	int          byte_col = 0;
	logic        bm_busy = 1'b0;
	logic        bm_drawn = 1'b0;

	// handshake and pacing bookkeeping
	logic item_taken = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int cycle_count = 0;
	int mismatch_count = 0;
	frag_t want;

	always #5 clk = ~clk;

	bitmap_fragment_expander dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (drv_item.cmd),
		.value_x    (drv_item.vx),
		.value_y    (drv_item.vy),
		.step_x     (drv_item.sx),
		.step_y     (drv_item.sy),
		.size_w     (drv_item.w),
		.size_h     (drv_item.h),
		.raster_ok  (drv_item.ok),
		.data_byte  (drv_item.data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frag_x     (frag_x),
		.frag_y     (frag_y),
		.last_of_run(last_of_run)
	);

	// subpixel position plus offset plus one half, floored to whole pixels
	function automatic int pixel_anchor(input logic [19:0] p, input logic [19:0] o);
		int s;
		s = $signed(p) + $signed(o) + (1 << (SUBPIX - 1));
		return s >>> SUBPIX;
	endfunction

	// on the surface and inside the scissor span along one axis
	function automatic bit on_surface(input int p, input int org, input int span);
		return p >= 0 && p < SURFACE && p - org >= 0 && p - org < span;
	endfunction

	// advance the model by one accepted transfer and queue the fragments it draws
	task automatic expand_item(input bitmap_item_t it);
		int align, row_len, first, px, n;
		case (it.cmd)
		CMD_SET: begin
			bm_busy = 1'b0;
			pos_x = it.vx;
			pos_y = it.vy;
			pos_ok = it.ok;
		end
		CMD_BEGIN: begin
			bm_busy = 1'b0;
			move_x = it.sx;
			move_y = it.sy;
			if (it.w == 0 || it.h == 0) begin
				// empty bitmap moves a valid raster at once
				if (pos_ok) begin
					pos_x += move_x;
					pos_y += move_y;
				end
			end else begin
				bm_drawn = pos_ok;
				if (pos_ok) begin
					row_x0 = pixel_anchor(pos_x, it.vx);
					row_y = pixel_anchor(pos_y, it.vy);
				end
				bm_width = it.w;
				rows_left = it.h;
				byte_col = 0;
				bm_busy = 1'b1;
			end
		end
		CMD_DATA: if (bm_busy) begin
			align = 1 << cfg_align;
			row_len = align * ((bm_width + 8 * align - 1) / (8 * align));
			first = byte_col * 8;
			n = 0;
			if (bm_drawn && first < bm_width && on_surface(row_y, cfg_org_y, cfg_span_h)) begin
				// msb first, bits past the width are dropped
				for (int i = 0; i < 8 && first + i < bm_width; i++) begin
					px = row_x0 + first + i;
					if (it.data[7 - i] && on_surface(px, cfg_org_x, cfg_span_w)) begin
						pending_frags.push_back('{x: px[11:0], y: row_y[11:0], last: 1'b0});
						n++;
					end
				end
				if (n > 0)
					pending_frags[pending_frags.size() - 1].last = 1'b1;
			end
			byte_col++;
			if (byte_col >= row_len) begin
				byte_col = 0;
				row_y++;
				rows_left--;
				if (rows_left == 0) begin
					bm_busy = 1'b0;
					if (bm_drawn) begin
						pos_x += move_x;
						pos_y += move_y;
					end
				end
			end
		end
		default: ;
		endcase
	endtask

	function automatic bitmap_item_t random_item();
		bitmap_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.vx = 20'($urandom);
		it.vy = 20'($urandom);
		it.sx = 20'($urandom);
		it.sy = 20'($urandom);
		it.w = 12'($urandom);
		it.h = 12'($urandom);
		it.ok = 1'($urandom);
		it.data = 8'($urandom);
		return it;
	endfunction

	// unused fields stay random so every input bit toggles
	task automatic add_set(input int x, input int y, input logic ok);
		bitmap_item_t it;
		it = random_item();
		it.cmd = CMD_SET;
		it.vx = 20'(x);
		it.vy = 20'(y);
		it.ok = ok;
		bitmap_items.push_back(it);
	endtask

	task automatic add_begin(input int w, input int h, input int ox,
			input int oy, input int sx, input int sy);
		bitmap_item_t it;
		it = random_item();
		it.cmd = CMD_BEGIN;
		it.w = 12'(w);
		it.h = 12'(h);
		it.vx = 20'(ox);
		it.vy = 20'(oy);
		it.sx = 20'(sx);
		it.sy = 20'(sy);
		bitmap_items.push_back(it);
	endtask

	task automatic add_data(input logic [7:0] b);
		bitmap_item_t it;
		it = random_item();
		it.cmd = CMD_DATA;
		it.data = b;
		bitmap_items.push_back(it);
	endtask

	// mostly whole bitmaps placed around the scissor corner, some truncated, some noise
	task automatic queue_random(input int count);
		int made, px, py, w, h, align, n_bytes;
		int ox, oy, sx, sy;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 7) == 0) begin
				bitmap_items.push_back(random_item());
				made++;
			end else begin
				if ($urandom_range(0, 4) != 0) begin
					px = cfg_org_x - 12 + $urandom_range(0, 52);
					py = cfg_org_y - 4 + $urandom_range(0, 30);
					add_set(px * 16 + $urandom_range(0, 15), py * 16 + $urandom_range(0, 15),
						$urandom_range(0, 9) != 0);
					made++;
				end
				w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
				h = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 4);
				ox = $urandom_range(0, 80) - 40;
				oy = $urandom_range(0, 80) - 40;
				sx = $urandom;
				sy = $urandom;
				if ($urandom_range(0, 3) != 0) begin
					sx = $urandom_range(0, 640) - 320;
					sy = $urandom_range(0, 96) - 48;
				end
				add_begin(w, h, ox, oy, sx, sy);
				made++;
				align = 1 << cfg_align;
				n_bytes = (w == 0 || h == 0) ? 0 :
					h * align * ((w + 8 * align - 1) / (8 * align));
				// now and then cut the bitmap short
				if ($urandom_range(0, 9) == 0)
					n_bytes = $urandom_range(0, n_bytes);
				repeat (n_bytes) begin
					case ($urandom_range(0, 7))
					0, 1: add_data(8'hFF);
					2: add_data(8'h00);
					default: add_data(8'($urandom));
					endcase
					made++;
				end
			end
		end
	endtask

	// one register write on the next clock edge, mirrored into the model
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_ALIGN:    cfg_align = val & 3;
		CFG_ORIGIN_X: cfg_org_x = val & 12'hFFF;
		CFG_ORIGIN_Y: cfg_org_y = val & 12'hFFF;
		CFG_SPAN_W:   cfg_span_w = val & 13'h1FFF;
		CFG_SPAN_H:   cfg_span_h = val & 13'h1FFF;
		default: ;
		endcase
	endtask

	task automatic apply_setting(input int align, input int ox, input int oy,
			input int sw, input int sh);
		write_reg(CFG_ALIGN, align);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_SPAN_W, sw);
		write_reg(CFG_SPAN_H, sh);
	endtask

	// all items sent, all fragments seen, then let silent jobs drain out
	task automatic wait_idle();
		int waited;
		while (bitmap_items.size() != 0 || in_valid)
			@(posedge clk);
		waited = 0;
		while (pending_frags.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_frags.size() != 0) begin
			$display("%0t %0d fragments never arrived, first expected x %0d y %0d last %0b",
				$time, pending_frags.size(), pending_frags[0].x, pending_frags[0].y,
				pending_frags[0].last);
			mismatch_count++;
			pending_frags.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// input driver: next item once the current one transferred, paced in bursts
	always @(negedge clk) begin
		if (arst_n && (!in_valid || item_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (bitmap_items.size() > 0) begin
				drv_item <= bitmap_items.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// fragment receiver: stall behavior switches among none, coin, beat and heavy modes at random
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 50 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
		STALL_NONE:  out_stall <= 1'b0;
		STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
		STALL_BEAT:  out_stall <= (stall_tick % 9) < 5;
		STALL_HEAVY: out_stall <= $urandom_range(0, 7) != 0;
		default:     out_stall <= 1'b0;
		endcase
	end

	// monitor: predict on every input transfer, check every fragment transfer
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		item_taken = arst_n && in_valid && !in_stall;
		if (item_taken)
			expand_item(drv_item);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frags.size() == 0) begin
				$display("%0t fragment expected none got x %0d y %0d last %0b",
					$time, frag_x, frag_y, last_of_run);
				mismatch_count++;
			end else begin
				want = pending_frags.pop_front();
				if (frag_x !== want.x) begin
					$display("%0t frag_x expected %0d got %0d", $time, want.x, frag_x);
					mismatch_count++;
				end
				if (frag_y !== want.y) begin
					$display("%0t frag_y expected %0d got %0d", $time, want.y, frag_y);
					mismatch_count++;
				end
				if (last_of_run !== want.last) begin
					$display("%0t last_of_run expected %0b got %0b", $time, want.last,
						last_of_run);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		// directed part, run at the reset register values
		add_data(8'hFF);                              // data while idle is dropped
		begin
			bitmap_item_t junk;
			junk = random_item();
			junk.cmd = CMD_UNUSED;
			bitmap_items.push_back(junk);
		end
		// zero width moves the raster by the extreme steps right away
		add_begin(0, 3, 20'h0, 20'h0, 20'h7FFFF, 20'h80000);
		// extreme offsets cancel the moved raster: anchor lands at (0,0)
		add_begin(12'hFFF, 12'hFFF, 20'h80000, 20'h7FFFF, 20'h0, 20'h0);
		add_data(8'hFF);
		add_set(16 * 100 + 3, 16 * 50 + 9, 1'b1);    // abandons the huge bitmap
		add_begin(12, 1, -8, 0, 16 * 12, 0);
		add_data(8'hA5);
		add_data(8'hFF);                              // lower half past the width
		add_data(8'h33);                              // padding bytes
		add_data(8'hCC);
		add_set(20'h80000, 20'h7FFFF, 1'b0);          // invalid raster swallows the byte
		add_begin(3, 1, 0, 0, 16, 16);
		add_data(8'hFF);
		add_set(16 * 4092, 16 * 4095, 1'b1);          // right and top surface edge
		add_begin(9, 2, 0, 0, 0, 0);
		add_data(8'hFF);
		add_data(8'hC0);
		add_data(8'h5A);
		add_data(8'h5A);
		add_data(8'hFF);                              // second row falls off the top
		add_data(8'hFF);
		add_data(8'h00);
		add_data(8'h00);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_idle();

		queue_random(10);
		wait_idle();
		apply_setting(0, 100, 50, 64, 40);            // byte rows, tight window
		queue_random(10);
		wait_idle();
		apply_setting(3, 0, 0, 4096, 4096);           // eight byte rows, full surface
		queue_random(10);
		wait_idle();
		apply_setting(1, 4095, 4095, 1, 1);           // only the far corner pixel
		queue_random(10);
		wait_idle();
		apply_setting(2, 2000, 1000, 0, 4096);        // empty window
		queue_random(6);
		wait_idle();
		apply_setting(0, 7, 3, 4096, 4096);
		queue_random(10);
		wait_idle();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
